FILE: src/hpl_pkg.sv
// shared types, constants and helpers for the half-space point load response block
// no dependencies
package hpl_pkg;

  // configuration register index
  localparam int unsigned CfgIdxW = 2;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_GRID_SPACING = 2'd0;
  localparam cfg_idx_t REG_VERT_COEFF   = 2'd1;
  localparam cfg_idx_t REG_HORI_COEFF   = 2'd2;

  localparam logic [31:0] GridSpacingRst = 32'd256;

  // quadrant codes that flip signs
  typedef logic [2:0] quad_t;
  localparam quad_t QUAD_NEG_Y   = 3'd2;
  localparam quad_t QUAD_NEG_XY  = 3'd3;
  localparam quad_t QUAD_NEG_X   = 3'd4;

  // direction cosine width (Q1.16, at most 2^16) and wide quotient width
  localparam int unsigned CosW = 17;
  localparam int unsigned DivW = 32 + CosW;

  typedef logic [31:0] word_t;

  // saturate a magnitude with a sign into 32-bit two's complement
  function automatic word_t sat_signed(input logic [DivW-1:0] mag, input logic neg);
    logic [DivW-1:0] lim;
    logic [DivW-1:0] m;
    begin
      lim = neg ? DivW'(33'h0_8000_0000) : DivW'(33'h0_7FFF_FFFF);
      m = (mag > lim) ? lim : mag;
      sat_signed = neg ? (32'd0 - m[31:0]) : m[31:0];
    end
  endfunction

endpackage

FILE: src/halfspace_point_load_response.sv
// top level of the half-space point load response pipeline
// depends on hpl_pkg
//
// usage:
//   items enter on start with grid_x_i, grid_y_i, quadrant_i; busy stays low,
//   so a new item may enter in every cycle.
//   each item yields one result on disp_x_o, disp_y_o, disp_z_o, marked by a
//   one-cycle valid_o strobe.
//   the pipeline holds the digit-by-digit square root (one root bit per
//   stage), the direction cosine divider (17 stages) and the wide response
//   divider (49 stages, one quotient bit per stage).
//   throughput is one item per cycle; every stage moves each cycle.
//   registers are written through cfg_valid_i / cfg_ready_o with cfg_index_i and
//   cfg_data_i; cfg_ready_o is always high, and writes must be made while no
//   item is in flight; the block itself does not enforce this.
//   reset clears all valid bits and loads grid_spacing 256, coefficients 0.
//   the receiver cannot stall: each result is shown for exactly one cycle.
module halfspace_point_load_response #(
  parameter int unsigned INDEX_WIDTH = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [INDEX_WIDTH-1:0] grid_x_i,
  input  logic signed [INDEX_WIDTH-1:0] grid_y_i,
  input  hpl_pkg::quad_t            quadrant_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  hpl_pkg::cfg_idx_t         cfg_index_i,
  input  hpl_pkg::word_t            cfg_data_i,
  output logic                      valid_o,
  output logic signed [31:0]        disp_x_o,
  output logic signed [31:0]        disp_y_o,
  output logic signed [31:0]        disp_z_o
);
  import hpl_pkg::*;

  localparam int unsigned W   = INDEX_WIDTH;
  localparam int unsigned SRW = W + 8;       // root width
  localparam int unsigned RW  = W + 32;      // distance width
  localparam int unsigned LAT = SRW + CosW + DivW + 5;

  // configuration registers
  word_t grid_spacing_q, vert_coeff_q, hori_coeff_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_spacing_q <= GridSpacingRst;
      vert_coeff_q   <= '0;
      hori_coeff_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_GRID_SPACING: grid_spacing_q <= cfg_data_i;
        REG_VERT_COEFF:   vert_coeff_q   <= cfg_data_i;
        REG_HORI_COEFF:   hori_coeff_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage a: offset magnitudes
  logic         a_v_q;
  logic [W-1:0] a_ax_q, a_ay_q;
  quad_t        a_quad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q <= 1'b0;
    else         a_v_q <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    a_ax_q   <= grid_x_i[W-1] ? (~grid_x_i + W'(1)) : grid_x_i;
    a_ay_q   <= grid_y_i[W-1] ? (~grid_y_i + W'(1)) : grid_y_i;
    a_quad_q <= quadrant_i;
  end

  // square root pipeline, entry 0 holds the squared norm
  logic             sq_v_q    [SRW+1];
  logic [2*SRW-1:0] sq_rad_q  [SRW+1];
  logic [SRW:0]     sq_rem_q  [SRW+1];
  logic [SRW-1:0]   sq_root_q [SRW+1];
  logic [W-1:0]     sq_ax_q   [SRW+1];
  logic [W-1:0]     sq_ay_q   [SRW+1];
  quad_t            sq_quad_q [SRW+1];
  logic             sq_zero_q [SRW+1];

  logic [2*W-1:0] n2_sum;
  always_comb begin
    n2_sum = (2*W)'(a_ax_q) * (2*W)'(a_ax_q) + (2*W)'(a_ay_q) * (2*W)'(a_ay_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_v_q[0] <= 1'b0;
    else         sq_v_q[0] <= a_v_q;
  end

  always_ff @(posedge clk_i) begin
    sq_rad_q[0]  <= {n2_sum, 16'd0};
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
    sq_ax_q[0]   <= a_ax_q;
    sq_ay_q[0]   <= a_ay_q;
    sq_quad_q[0] <= a_quad_q;
    sq_zero_q[0] <= (n2_sum == '0);
  end

  for (genvar k = 1; k <= SRW; k++) begin : g_sqrt
    logic [SRW+2:0] t, trial;
    logic           ge;
    always_comb begin
      t     = {sq_rem_q[k-1], sq_rad_q[k-1][2*SRW-1 -: 2]};
      trial = {1'b0, sq_root_q[k-1], 2'b01};
      ge    = (t >= trial);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[k] <= 1'b0;
      else         sq_v_q[k] <= sq_v_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      sq_rad_q[k]  <= sq_rad_q[k-1] << 2;
      sq_rem_q[k]  <= ge ? (SRW+1)'(t - trial) : t[SRW:0];
      sq_root_q[k] <= {sq_root_q[k-1][SRW-2:0], ge};
      sq_ax_q[k]   <= sq_ax_q[k-1];
      sq_ay_q[k]   <= sq_ay_q[k-1];
      sq_quad_q[k] <= sq_quad_q[k-1];
      sq_zero_q[k] <= sq_zero_q[k-1];
    end
  end

  // cosine divider pipeline, entry 0 holds the distance in meters
  logic             cx_v_q    [CosW+1];
  logic [SRW:0]     cx_rx_q   [CosW+1];
  logic [SRW:0]     cx_ry_q   [CosW+1];
  logic [CosW-1:0]  cx_qx_q   [CosW+1];
  logic [CosW-1:0]  cx_qy_q   [CosW+1];
  logic [SRW-1:0]   cx_root_q [CosW+1];
  logic [RW-1:0]    cx_r_q    [CosW+1];
  quad_t            cx_quad_q [CosW+1];
  logic             cx_zero_q [CosW+1];

  logic [SRW+31:0] dist_prod;
  assign dist_prod = (SRW+32)'(grid_spacing_q) * (SRW+32)'(sq_root_q[SRW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cx_v_q[0] <= 1'b0;
    else         cx_v_q[0] <= sq_v_q[SRW];
  end

  always_ff @(posedge clk_i) begin
    cx_rx_q[0]   <= {2'b00, sq_ax_q[SRW], 7'd0};
    cx_ry_q[0]   <= {2'b00, sq_ay_q[SRW], 7'd0};
    cx_qx_q[0]   <= '0;
    cx_qy_q[0]   <= '0;
    cx_root_q[0] <= sq_root_q[SRW];
    cx_r_q[0]    <= dist_prod[RW+7:8];
    cx_quad_q[0] <= sq_quad_q[SRW];
    cx_zero_q[0] <= sq_zero_q[SRW];
  end

  for (genvar k = 1; k <= CosW; k++) begin : g_cos
    logic [SRW+1:0] tx, ty, dv;
    logic           gx, gy;
    always_comb begin
      tx = {cx_rx_q[k-1], 1'b0};
      ty = {cx_ry_q[k-1], 1'b0};
      dv = {2'b00, cx_root_q[k-1]};
      gx = (tx >= dv);
      gy = (ty >= dv);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) cx_v_q[k] <= 1'b0;
      else         cx_v_q[k] <= cx_v_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      cx_rx_q[k]   <= gx ? (SRW+1)'(tx - dv) : tx[SRW:0];
      cx_ry_q[k]   <= gy ? (SRW+1)'(ty - dv) : ty[SRW:0];
      cx_qx_q[k]   <= {cx_qx_q[k-1][CosW-2:0], gx};
      cx_qy_q[k]   <= {cx_qy_q[k-1][CosW-2:0], gy};
      cx_root_q[k] <= cx_root_q[k-1];
      cx_r_q[k]    <= cx_r_q[k-1];
      cx_quad_q[k] <= cx_quad_q[k-1];
      cx_zero_q[k] <= cx_zero_q[k-1];
    end
  end

  // response divider pipeline, entry 0 holds the scaled numerators
  logic             dv_v_q    [DivW+1];
  logic [RW-1:0]    dv_rx_q   [DivW+1];
  logic [RW-1:0]    dv_ry_q   [DivW+1];
  logic [RW-1:0]    dv_rz_q   [DivW+1];
  logic [DivW-1:0]  dv_qx_q   [DivW+1];
  logic [DivW-1:0]  dv_qy_q   [DivW+1];
  logic [DivW-1:0]  dv_qz_q   [DivW+1];
  logic [RW-1:0]    dv_r_q    [DivW+1];
  quad_t            dv_quad_q [DivW+1];
  logic             dv_zero_q [DivW+1];

  word_t hmag, vmag;
  assign hmag = hori_coeff_q[31] ? (32'd0 - hori_coeff_q) : hori_coeff_q;
  assign vmag = vert_coeff_q[31] ? (32'd0 - vert_coeff_q) : vert_coeff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q[0] <= 1'b0;
    else         dv_v_q[0] <= cx_v_q[CosW];
  end

  always_ff @(posedge clk_i) begin
    dv_rx_q[0]   <= '0;
    dv_ry_q[0]   <= '0;
    dv_rz_q[0]   <= '0;
    dv_qx_q[0]   <= DivW'(hmag) * DivW'(cx_qx_q[CosW]);
    dv_qy_q[0]   <= DivW'(hmag) * DivW'(cx_qy_q[CosW]);
    dv_qz_q[0]   <= DivW'(vmag);
    dv_r_q[0]    <= cx_r_q[CosW];
    dv_quad_q[0] <= cx_quad_q[CosW];
    dv_zero_q[0] <= cx_zero_q[CosW] || (cx_r_q[CosW] == '0);
  end

  for (genvar k = 1; k <= DivW; k++) begin : g_div
    logic [RW:0] tx, ty, tz, dd;
    logic        gx, gy, gz;
    always_comb begin
      tx = {dv_rx_q[k-1], dv_qx_q[k-1][DivW-1]};
      ty = {dv_ry_q[k-1], dv_qy_q[k-1][DivW-1]};
      tz = {dv_rz_q[k-1], dv_qz_q[k-1][DivW-1]};
      dd = {1'b0, dv_r_q[k-1]};
      gx = (tx >= dd);
      gy = (ty >= dd);
      gz = (tz >= dd);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[k] <= 1'b0;
      else         dv_v_q[k] <= dv_v_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      dv_rx_q[k]   <= gx ? RW'(tx - dd) : tx[RW-1:0];
      dv_ry_q[k]   <= gy ? RW'(ty - dd) : ty[RW-1:0];
      dv_rz_q[k]   <= gz ? RW'(tz - dd) : tz[RW-1:0];
      dv_qx_q[k]   <= {dv_qx_q[k-1][DivW-2:0], gx};
      dv_qy_q[k]   <= {dv_qy_q[k-1][DivW-2:0], gy};
      dv_qz_q[k]   <= {dv_qz_q[k-1][DivW-2:0], gz};
      dv_r_q[k]    <= dv_r_q[k-1];
      dv_quad_q[k] <= dv_quad_q[k-1];
      dv_zero_q[k] <= dv_zero_q[k-1];
    end
  end

  // sign, saturate and register the result
  logic  neg_x, neg_y, neg_z, flip_x, flip_y;
  quad_t fq;
  word_t res_x, res_y, res_z;

  always_comb begin
    fq     = dv_quad_q[DivW];
    flip_x = (fq == QUAD_NEG_XY) || (fq == QUAD_NEG_X);
    flip_y = (fq == QUAD_NEG_XY) || (fq == QUAD_NEG_Y);
    neg_x  = hori_coeff_q[31] ^ flip_x;
    neg_y  = hori_coeff_q[31] ^ flip_y;
    neg_z  = vert_coeff_q[31];
    res_x  = sat_signed(dv_qx_q[DivW] >> 16, neg_x);
    res_y  = sat_signed(dv_qy_q[DivW] >> 16, neg_y);
    res_z  = sat_signed(dv_qz_q[DivW], neg_z);
  end

  logic  out_v_q;
  word_t out_x_q, out_y_q, out_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else         out_v_q <= dv_v_q[DivW];
  end

  always_ff @(posedge clk_i) begin
    out_x_q <= dv_zero_q[DivW] ? '0 : res_x;
    out_y_q <= dv_zero_q[DivW] ? '0 : res_y;
    out_z_q <= dv_zero_q[DivW] ? '0 : res_z;
  end

  assign valid_o  = out_v_q;
  assign disp_x_o = out_x_q;
  assign disp_y_o = out_y_q;
  assign disp_z_o = out_z_q;

  // each result traces back to an item taken a fixed latency earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, LAT))
    else $error("result without a matching item");

  // a nonzero offset always gives a root of at least one grid unit
  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cx_v_q[0] && !cx_zero_q[0]) |-> (cx_root_q[0] >= SRW'(256)))
    else $error("root too small for a nonzero offset");

  // zero coefficients give zero responses
  a_vert_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && vert_coeff_q == '0) |-> (disp_z_o == '0))
    else $error("vertical response with zero coefficient");

  a_hori_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && hori_coeff_q == '0) |-> (disp_x_o == '0 && disp_y_o == '0))
    else $error("horizontal response with zero coefficient");

endmodule
